// ----- rtl/core/tiap_pkg.sv -----
// shared constants, types and rom tables for the arccos / arcsin interpolator
`default_nettype none
package tiap_pkg;

  // command codes
  typedef enum logic {
    CMD_ACOS = 1'b0,
    CMD_ASIN = 1'b1
  } cmd_e;

  // rom segment select
  typedef enum logic [1:0] {
    SEG_MAIN = 2'd0,
    SEG_NEAR = 2'd1,
    SEG_END  = 2'd2
  } seg_e;

  localparam int unsigned MAG_W   = 15;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned FRAC_W  = 9;
  localparam int unsigned DIFF_W  = 10;
  localparam int unsigned PROD_W  = DIFF_W + FRAC_W;

  localparam logic [MAG_W-1:0]   NEAR_START  = 15'h7800;
  localparam logic [MAG_W-1:0]   END_START   = 15'h7FE0;
  localparam logic [MAG_W-1:0]   MAG_MAX     = 15'h7FFF;
  localparam logic [ANGLE_W-1:0] ACOS_NEG    = 16'hFFFF;
  localparam logic [ANGLE_W-1:0] ASIN_POS    = 16'h7FFF;
  localparam logic [ANGLE_W-1:0] ASIN_NEG    = 16'h8000;

  // coarse table, step 512 below 0x7800
  function automatic logic [ANGLE_W-1:0] main_rom_f(input logic [IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] r;
    unique case (idx)
      6'd0:  r = 16'h8000; 6'd1:  r = 16'h7EBA; 6'd2:  r = 16'h7D74; 6'd3:  r = 16'h7C2D;
      6'd4:  r = 16'h7AE7; 6'd5:  r = 16'h79A0; 6'd6:  r = 16'h7859; 6'd7:  r = 16'h7711;
      6'd8:  r = 16'h75C9; 6'd9:  r = 16'h7480; 6'd10: r = 16'h7337; 6'd11: r = 16'h71EC;
      6'd12: r = 16'h70A1; 6'd13: r = 16'h6F55; 6'd14: r = 16'h6E07; 6'd15: r = 16'h6CB8;
      6'd16: r = 16'h6B68; 6'd17: r = 16'h6A17; 6'd18: r = 16'h68C4; 6'd19: r = 16'h6770;
      6'd20: r = 16'h661A; 6'd21: r = 16'h64C1; 6'd22: r = 16'h6367; 6'd23: r = 16'h620B;
      6'd24: r = 16'h60AD; 6'd25: r = 16'h5F4C; 6'd26: r = 16'h5DE9; 6'd27: r = 16'h5C83;
      6'd28: r = 16'h5B1A; 6'd29: r = 16'h59AE; 6'd30: r = 16'h583E; 6'd31: r = 16'h56CB;
      6'd32: r = 16'h5555; 6'd33: r = 16'h53DB; 6'd34: r = 16'h525C; 6'd35: r = 16'h50D9;
      6'd36: r = 16'h4F51; 6'd37: r = 16'h4DC5; 6'd38: r = 16'h4C32; 6'd39: r = 16'h4A9A;
      6'd40: r = 16'h48FC; 6'd41: r = 16'h4757; 6'd42: r = 16'h45AB; 6'd43: r = 16'h43F7;
      6'd44: r = 16'h423A; 6'd45: r = 16'h4075; 6'd46: r = 16'h3EA5; 6'd47: r = 16'h3CCB;
      6'd48: r = 16'h3AE5; 6'd49: r = 16'h38F1; 6'd50: r = 16'h36EF; 6'd51: r = 16'h34DC;
      6'd52: r = 16'h32B7; 6'd53: r = 16'h307D; 6'd54: r = 16'h2E2B; 6'd55: r = 16'h2BBD;
      6'd56: r = 16'h292E; 6'd57: r = 16'h2678; 6'd58: r = 16'h2391; 6'd59: r = 16'h206C;
      6'd60: r = 16'h1CF6;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // fine table, step 32 from 0x7800
  function automatic logic [ANGLE_W-1:0] near_rom_f(input logic [IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] r;
    unique case (idx)
      6'd0:  r = 16'h1CF6; 6'd1:  r = 16'h1CBB; 6'd2:  r = 16'h1C80; 6'd3:  r = 16'h1C45;
      6'd4:  r = 16'h1C08; 6'd5:  r = 16'h1BCC; 6'd6:  r = 16'h1B8F; 6'd7:  r = 16'h1B51;
      6'd8:  r = 16'h1B13; 6'd9:  r = 16'h1AD4; 6'd10: r = 16'h1A95; 6'd11: r = 16'h1A55;
      6'd12: r = 16'h1A14; 6'd13: r = 16'h19D3; 6'd14: r = 16'h1992; 6'd15: r = 16'h194F;
      6'd16: r = 16'h190C; 6'd17: r = 16'h18C9; 6'd18: r = 16'h1884; 6'd19: r = 16'h183F;
      6'd20: r = 16'h17F9; 6'd21: r = 16'h17B3; 6'd22: r = 16'h176B; 6'd23: r = 16'h1723;
      6'd24: r = 16'h16DA; 6'd25: r = 16'h1690; 6'd26: r = 16'h1645; 6'd27: r = 16'h15F9;
      6'd28: r = 16'h15AC; 6'd29: r = 16'h155E; 6'd30: r = 16'h150F; 6'd31: r = 16'h14BE;
      6'd32: r = 16'h146D; 6'd33: r = 16'h141A; 6'd34: r = 16'h13C6; 6'd35: r = 16'h1370;
      6'd36: r = 16'h1319; 6'd37: r = 16'h12C1; 6'd38: r = 16'h1267; 6'd39: r = 16'h120B;
      6'd40: r = 16'h11AD; 6'd41: r = 16'h114E; 6'd42: r = 16'h10EC; 6'd43: r = 16'h1088;
      6'd44: r = 16'h1022; 6'd45: r = 16'h0FB9; 6'd46: r = 16'h0F4D; 6'd47: r = 16'h0EDE;
      6'd48: r = 16'h0E6C; 6'd49: r = 16'h0DF7; 6'd50: r = 16'h0D7D; 6'd51: r = 16'h0D00;
      6'd52: r = 16'h0C7D; 6'd53: r = 16'h0BF4; 6'd54: r = 16'h0B66; 6'd55: r = 16'h0AD0;
      6'd56: r = 16'h0A31; 6'd57: r = 16'h0989; 6'd58: r = 16'h08D3; 6'd59: r = 16'h080E;
      6'd60: r = 16'h0734; 6'd61: r = 16'h063D; 6'd62: r = 16'h0518; 6'd63: r = 16'h039A;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // endpoint table, step 8 from 0x7FE0, the default zero closes the final interval
  function automatic logic [ANGLE_W-1:0] end_rom_f(input logic [2:0] idx);
    logic [ANGLE_W-1:0] r;
    unique case (idx)
      3'd0:    r = 16'h039A;
      3'd1:    r = 16'h031E;
      3'd2:    r = 16'h028C;
      3'd3:    r = 16'h01CD;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/table_interp_arccos_arcsin.sv -----
// top level of the table interpolating arccos / arcsin unit
`default_nettype none
// Arccos / arcsin of a signed Q15 argument, result as a 16-bit binary angle
// (0x10000 is a half turn; arcsin results are two's complement bits). The
// magnitude is interpolated linearly in one of three constant tables: a
// coarse one below 0x7800, a fine one up to 0x7FDF and an endpoint one from
// 0x7FE0; a magnitude of 32768 is clamped to 32767. Timing: a word is taken
// into an input register, goes through one pass of table reads, a 10x9
// multiply and the sign mapping, and lands in the output register, where its
// result is shown; while the output is not stalled, one word is taken every
// cycle. That one register-to-register pass through the tables
// and the multiplier is what sets the clock. in_stall_o rises only when the
// input register is full and the output register is full and stalled.
module table_interp_arccos_arcsin (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic signed [15:0]             value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tiap_pkg::ANGLE_W-1:0]   angle_o
);

  // input register
  logic                           s1_valid_q;
  logic                           s1_cmd_q;
  logic signed [15:0]             s1_value_q;
  // output register
  logic                           out_valid_q;
  logic [tiap_pkg::ANGLE_W-1:0]   angle_q;
  logic [tiap_pkg::ANGLE_W-1:0]   angle_d;

  logic                           s2_ready;
  logic                           s1_ready;
  logic                           in_take;
  logic                           neg;
  logic [15:0]                    mag_full;
  logic [tiap_pkg::MAG_W-1:0]     mag;
  logic [tiap_pkg::ANGLE_W-1:0]   mag_angle;
  tiap_pkg::cmd_e                 cmd;

  // handshake: output slot frees when empty or being taken
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_take    = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload only loads on a taken word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q   <= command_i;
      s1_value_q <= value_i;
    end
  end

  // magnitude of the argument, most negative value clamped
  assign neg      = s1_value_q[15];
  assign mag_full = neg ? (~s1_value_q + 16'sd1) : s1_value_q;
  assign mag      = mag_full[15] ? tiap_pkg::MAG_MAX : mag_full[tiap_pkg::MAG_W-1:0];

  tiap_interp u_interp (
    .mag_i   (mag),
    .angle_o (mag_angle)
  );

  // quadrant mapping by command and sign
  assign cmd = tiap_pkg::cmd_e'(s1_cmd_q);

  always_comb begin
    unique case (cmd)
      tiap_pkg::CMD_ACOS: angle_d = neg ? (tiap_pkg::ACOS_NEG - mag_angle) : mag_angle;
      tiap_pkg::CMD_ASIN: angle_d = neg ? (mag_angle - tiap_pkg::ASIN_NEG)
                                        : (tiap_pkg::ASIN_POS - mag_angle);
      default:            angle_d = mag_angle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

`ifndef SYNTHESIS
  // a taken word always occupies the input register next cycle
  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted word not held in input register");

  // a word leaving the input register shows up as a result
  a_s1_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_o)
    else $error("word lost between input and output register");

  // stall only with both registers full and the output stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/tiap_interp.sv -----
// magnitude to angle by piecewise linear rom interpolation
`default_nettype none
module tiap_interp (
  input  logic [tiap_pkg::MAG_W-1:0]   mag_i,
  output logic [tiap_pkg::ANGLE_W-1:0] angle_o
);

  tiap_pkg::seg_e                  seg;
  logic [tiap_pkg::MAG_W-1:0]      near_off;
  logic [tiap_pkg::MAG_W-1:0]      end_off;
  logic [tiap_pkg::IDX_W-1:0]      idx;
  logic [tiap_pkg::IDX_W-1:0]      idx_nxt;
  logic [tiap_pkg::FRAC_W-1:0]     frac;
  logic [tiap_pkg::ANGLE_W-1:0]    t_val;
  logic [tiap_pkg::ANGLE_W-1:0]    u_val;
  logic [tiap_pkg::ANGLE_W-1:0]    diff_full;
  logic [tiap_pkg::DIFF_W-1:0]     diff;
  logic [tiap_pkg::PROD_W-1:0]     prod;
  logic [tiap_pkg::PROD_W-1:0]     scaled;

  assign near_off = mag_i - tiap_pkg::NEAR_START;
  assign end_off  = mag_i - tiap_pkg::END_START;

  always_comb begin
    if (mag_i >= tiap_pkg::END_START) begin
      seg = tiap_pkg::SEG_END;
    end else if (mag_i >= tiap_pkg::NEAR_START) begin
      seg = tiap_pkg::SEG_NEAR;
    end else begin
      seg = tiap_pkg::SEG_MAIN;
    end
  end

  // segment index, fraction and the two bracketing entries
  always_comb begin
    unique case (seg)
      tiap_pkg::SEG_END: begin
        idx   = {4'b0000, end_off[4:3]};
        frac  = {6'd0, end_off[2:0]};
      end
      tiap_pkg::SEG_NEAR: begin
        idx   = near_off[10:5];
        frac  = {4'd0, near_off[4:0]};
      end
      default: begin
        idx   = mag_i[14:9];
        frac  = mag_i[8:0];
      end
    endcase
  end

  assign idx_nxt = idx + 6'd1;

  always_comb begin
    unique case (seg)
      tiap_pkg::SEG_END: begin
        t_val = tiap_pkg::end_rom_f(idx[2:0]);
        u_val = tiap_pkg::end_rom_f(idx_nxt[2:0]);
      end
      tiap_pkg::SEG_NEAR: begin
        t_val = tiap_pkg::near_rom_f(idx);
        u_val = tiap_pkg::near_rom_f(idx_nxt);
      end
      default: begin
        t_val = tiap_pkg::main_rom_f(idx);
        u_val = tiap_pkg::main_rom_f(idx_nxt);
      end
    endcase
  end

  // tables are non-increasing and adjacent steps stay under 1024
  assign diff_full = t_val - u_val;
  assign diff      = diff_full[tiap_pkg::DIFF_W-1:0];
  assign prod      = {{tiap_pkg::FRAC_W{1'b0}}, diff} * {{tiap_pkg::DIFF_W{1'b0}}, frac};

  always_comb begin
    unique case (seg)
      tiap_pkg::SEG_END:  scaled = prod >> 3;
      tiap_pkg::SEG_NEAR: scaled = prod >> 5;
      default:            scaled = prod >> 9;
    endcase
  end

  assign angle_o = t_val - scaled[tiap_pkg::ANGLE_W-1:0];

endmodule
`default_nettype wire

// ----- test/table_interp_arccos_arcsin_check.sv -----
// checker for the arccos / arcsin interpolator: predicts each angle word and compares it
`timescale 1ns / 100ps
module table_interp_arccos_arcsin_check
  import tiap_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               command_i,
  input  logic signed [15:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  // first entry sits in the top bits
  localparam logic [61*16-1:0] COARSE_TBL = {
    16'h8000, 16'h7EBA, 16'h7D74, 16'h7C2D, 16'h7AE7, 16'h79A0, 16'h7859, 16'h7711,
    16'h75C9, 16'h7480, 16'h7337, 16'h71EC, 16'h70A1, 16'h6F55, 16'h6E07, 16'h6CB8,
    16'h6B68, 16'h6A17, 16'h68C4, 16'h6770, 16'h661A, 16'h64C1, 16'h6367, 16'h620B,
    16'h60AD, 16'h5F4C, 16'h5DE9, 16'h5C83, 16'h5B1A, 16'h59AE, 16'h583E, 16'h56CB,
    16'h5555, 16'h53DB, 16'h525C, 16'h50D9, 16'h4F51, 16'h4DC5, 16'h4C32, 16'h4A9A,
    16'h48FC, 16'h4757, 16'h45AB, 16'h43F7, 16'h423A, 16'h4075, 16'h3EA5, 16'h3CCB,
    16'h3AE5, 16'h38F1, 16'h36EF, 16'h34DC, 16'h32B7, 16'h307D, 16'h2E2B, 16'h2BBD,
    16'h292E, 16'h2678, 16'h2391, 16'h206C, 16'h1CF6};

  localparam logic [64*16-1:0] FINE_TBL = {
    16'h1CF6, 16'h1CBB, 16'h1C80, 16'h1C45, 16'h1C08, 16'h1BCC, 16'h1B8F, 16'h1B51,
    16'h1B13, 16'h1AD4, 16'h1A95, 16'h1A55, 16'h1A14, 16'h19D3, 16'h1992, 16'h194F,
    16'h190C, 16'h18C9, 16'h1884, 16'h183F, 16'h17F9, 16'h17B3, 16'h176B, 16'h1723,
    16'h16DA, 16'h1690, 16'h1645, 16'h15F9, 16'h15AC, 16'h155E, 16'h150F, 16'h14BE,
    16'h146D, 16'h141A, 16'h13C6, 16'h1370, 16'h1319, 16'h12C1, 16'h1267, 16'h120B,
    16'h11AD, 16'h114E, 16'h10EC, 16'h1088, 16'h1022, 16'h0FB9, 16'h0F4D, 16'h0EDE,
    16'h0E6C, 16'h0DF7, 16'h0D7D, 16'h0D00, 16'h0C7D, 16'h0BF4, 16'h0B66, 16'h0AD0,
    16'h0A31, 16'h0989, 16'h08D3, 16'h080E, 16'h0734, 16'h063D, 16'h0518, 16'h039A};

  localparam logic [5*16-1:0] TAIL_TBL = {16'h039A, 16'h031E, 16'h028C, 16'h01CD, 16'h0000};

  typedef struct {
    cmd_e               cmd;
    logic signed [15:0] arg;
    logic [ANGLE_W-1:0] angle;
  } angle_rec_t;

  angle_rec_t angle_q[$];
  int         fail_count = 0;

  function automatic logic [ANGLE_W-1:0] interp_angle(input cmd_e cmd,
                                                      input logic signed [15:0] arg);
    logic               neg;
    logic [15:0]        raw;
    int unsigned        mag, off, idx, sh, t, u, frac, m;
    logic [ANGLE_W-1:0] mv;
    neg = arg[15];
    raw = arg;
    mag = neg ? (32'h10000 - raw) : raw;
    if (mag > 32'h7FFF) mag = 32'h7FFF;  // -32768 clamps
    if (mag >= END_START) begin
      off = mag - END_START;
      sh  = 3;
      idx = off >> sh;
      if (idx > 3) idx = 3;
      t = TAIL_TBL[(4 - idx) * 16 +: 16];
      u = TAIL_TBL[(3 - idx) * 16 +: 16];
    end else if (mag >= NEAR_START) begin
      off = mag - NEAR_START;
      sh  = 5;
      idx = off >> sh;
      if (idx > 62) idx = 62;
      t = FINE_TBL[(63 - idx) * 16 +: 16];
      u = FINE_TBL[(62 - idx) * 16 +: 16];
    end else begin
      off = mag;
      sh  = 9;
      idx = off >> sh;
      if (idx > 59) idx = 59;
      t = COARSE_TBL[(60 - idx) * 16 +: 16];
      u = COARSE_TBL[(59 - idx) * 16 +: 16];
    end
    frac = off & ((32'd1 << sh) - 1);
    m  = t - (((t - u) * frac) >> sh);
    mv = m[15:0];
    if (cmd == CMD_ACOS) return neg ? (ACOS_NEG - mv) : mv;
    return neg ? (mv - ASIN_NEG) : (ASIN_POS - mv);
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // result side first: a word accepted at this edge cannot already be in the output
  always @(posedge clk_i) begin
    angle_rec_t rec;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (angle_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected angle word %h, nothing pending", angle_i);
          fail_count++;
        end else begin
          rec = angle_q.pop_front();
          if (angle_i !== rec.angle) begin
            if (fail_count < 10)
              $display("angle mismatch: cmd %0d value %0d expected %h got %h",
                       rec.cmd, rec.arg, rec.angle, angle_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rec.cmd   = cmd_e'(command_i);
        rec.arg   = value_i;
        rec.angle = interp_angle(rec.cmd, value_i);
        angle_q.push_back(rec);
      end
    end
    pending_o    = angle_q.size();
    fail_count_o = fail_count;
  end

endmodule

// ----- test/table_interp_arccos_arcsin_test.sv -----
// testbench top for the arccos / arcsin interpolator: stimulus, output stalls and verdict
`timescale 1ns / 100ps
module table_interp_arccos_arcsin_test;
  import tiap_pkg::*;

  localparam int CORNER_COUNT = 13;
  localparam int RANDOM_WORDS = 1924;
  localparam int CYCLE_LIMIT  = 1000000;  // watchdog bound on the whole run
  localparam int HOLD_CYCLES  = 200;      // long output hold-off
  localparam int DRAIN_CYCLES = 16;       // margin after the drain

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               command   = 1'b0;
  logic signed [15:0] value     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ANGLE_W-1:0] angle;
  int                 fail_count;
  int                 pending;

  // handshake between the sender and the receiver for the long hold-off
  bit hold_req   = 1'b0;
  // sender offers back to back words while set
  bit send_burst = 1'b0;

  table_interp_arccos_arcsin dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .angle_o     (angle)
  );

  table_interp_arccos_arcsin_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (command),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .angle_i      (angle),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short idle runs, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // boundaries of the three table segments, the extremes and the clamp case
  function automatic logic signed [15:0] corner_arg(input int k);
    case (k)
      0:       return 16'sd0;
      1:       return 16'sd1;
      2:       return -16'sd1;
      3:       return 16'sh4000;                   // mid table
      4:       return 16'(NEAR_START) - 16'sd1;    // last coarse step
      5:       return 16'(NEAR_START);             // first fine step
      6:       return -16'(NEAR_START);
      7:       return 16'(END_START) - 16'sd1;     // last fine step
      8:       return 16'(END_START);              // first endpoint step
      9:       return 16'sh7FF9;                   // final interval toward zero entry
      10:      return 16'sh7FFF;                   // largest positive
      11:      return -16'sh7FFF;
      default: return 16'sh8000;                   // most negative, magnitude clamps
    endcase
  endfunction

  // spread over the whole range with weight on the fine and endpoint segments
  function automatic logic signed [15:0] rand_arg();
    int          r;
    logic [15:0] mag;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return 16'($urandom);
      4, 5:       mag = 16'($urandom_range(16'h7700, 16'h7FFF));
      6:          mag = 16'($urandom_range(16'h7FD8, 16'h7FFF));
      7:          mag = 16'($urandom_range(0, 16'h03FF));
      8:          mag = 16'(corner_arg($urandom_range(0, CORNER_COUNT - 1)));
      default:    return ($urandom_range(0, 1) == 1) ? 16'sh8000 : 16'($urandom);
    endcase
    return ($urandom_range(0, 1) == 1) ? -mag : mag;
  endfunction

  // one word on the input channel, with a random gap ahead of it
  task automatic send_word(input cmd_e cmd, input logic signed [15:0] arg);
    int gap;
    gap = 0;
    if (!send_burst && $urandom_range(0, 99) < 35) gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= arg;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for the checker to have no angle outstanding
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // output side: random stall runs, quiet stretches, and one long hold-off on request
  initial begin : receiver
    int  run;
    int  held;
    int  cyc;
    bit  quiet;
    run   = 0;
    cyc   = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        // block fills up behind this and has to stall its input
        out_stall <= 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
        run      = 0;
      end else if (run > 0) begin
        out_stall <= 1'b1;
        run--;
      end else if (quiet || $urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        run = pick_gap() - 1;
      end
    end
  end

  initial begin : stimulus
    int k;
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner arguments under both commands
    for (k = 0; k < CORNER_COUNT; k++) begin
      send_word(CMD_ACOS, corner_arg(k));
      send_word(CMD_ASIN, corner_arg(k));
    end

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 128 == 0) send_burst = ($urandom_range(0, 2) == 0);
      // sender goes quiet until every angle is back
      if (n == 600) wait_drained();
      // long output hold-off while words keep coming
      if (n == 1200) begin
        send_burst = 1'b1;
        hold_req   = 1'b1;
      end
      send_word(cmd_e'($urandom_range(0, 1)), rand_arg());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
